// File: src/mnsc_pkg.sv
// Shared types and constants for the Manhattan nearest-seed classifier.
// Used by the interfaces, the controller, the datapath, the top level and the checker.
// Depends on nothing.
package mnsc_pkg;

    localparam int COUNT_W   = 7;
    localparam int IDX_W     = 6;
    localparam int COORD_W   = 10;
    localparam int DIST_W    = 10;
    localparam int SLOT_COUNT = 2 ** IDX_W;

    localparam int MAX_SEEDS_DEFAULT = 64;

    localparam logic [COUNT_W-1:0] SEED_COUNT_RESET = 7'd64;
    localparam logic [DIST_W-1:0]  DIST_BOUND       = 10'd999;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN_A,
        ST_DRAIN_B,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic               start;
        logic               wr_en;
        logic               rd_en;
        logic               rd_cmp;
        logic               rd_first;
        logic [COUNT_W-1:0] rd_idx;
        logic               capture;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               land;
    } seed_entry_t;

endpackage

// File: src/mnsc_if.sv
// Channel interfaces of the nearest-seed classifier: request, response and configuration.
// Depends on mnsc_pkg for field widths.
interface mnsc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [mnsc_pkg::IDX_W-1:0]    seed_slot;
    logic [mnsc_pkg::COORD_W-1:0]  seed_x;
    logic [mnsc_pkg::COORD_W-1:0]  seed_y;
    logic                          seed_land;
    logic [mnsc_pkg::COORD_W-1:0]  pixel_x;
    logic [mnsc_pkg::COORD_W-1:0]  pixel_y;

    modport source (output valid, func, seed_slot, seed_x, seed_y, seed_land,
                    pixel_x, pixel_y, input ready);
    modport sink   (input valid, func, seed_slot, seed_x, seed_y, seed_land,
                    pixel_x, pixel_y, output ready);
endinterface

interface mnsc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mnsc_pkg::IDX_W-1:0]    nearest_index;
    logic                          is_land;
    logic [mnsc_pkg::DIST_W-1:0]   best_distance;

    modport source (output valid, nearest_index, is_land, best_distance, input ready);
    modport sink   (input valid, nearest_index, is_land, best_distance, output ready);
endinterface

interface mnsc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mnsc_pkg::COUNT_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: src/mnsc_ctrl.sv
// Controller of the nearest-seed classifier: sequences loads, seed scans and result hand-off.
// Depends on mnsc_pkg.
module mnsc_ctrl #(
    parameter int MAX_SEEDS = mnsc_pkg::MAX_SEEDS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_func,
    output logic                         in_ready,
    input  logic                         cfg_valid,
    input  logic [mnsc_pkg::COUNT_W-1:0] cfg_data,
    output logic                         cfg_ready,
    input  logic                         out_ready,
    output logic                         out_valid,
    output mnsc_pkg::ctrl_cmd_t          cmd
);

    localparam int DEPTH = (MAX_SEEDS < mnsc_pkg::SLOT_COUNT) ? MAX_SEEDS
                                                              : mnsc_pkg::SLOT_COUNT;
    localparam logic [mnsc_pkg::COUNT_W-1:0] DEPTH_C = mnsc_pkg::COUNT_W'(DEPTH);

    mnsc_pkg::ctrl_state_t        state_reg, state_next;
    logic [mnsc_pkg::COUNT_W-1:0] idx_reg, idx_next;
    logic [mnsc_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic [mnsc_pkg::COUNT_W-1:0] seed_count_reg, seed_count_next;
    logic                         out_valid_reg, out_valid_next;
    logic [mnsc_pkg::COUNT_W-1:0] scan_n;
    logic                         scan_last;

    // At least entry 0 is always read so that its class flag is known.
    assign scan_n    = (cnt_reg == '0) ? mnsc_pkg::COUNT_W'(1) : cnt_reg;
    assign scan_last = ((idx_reg + mnsc_pkg::COUNT_W'(1)) >= scan_n);

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    // Outputs and commands.
    always_comb
    begin
        cmd          = '0;
        in_ready     = 1'b0;
        cmd.rd_idx   = idx_reg;
        case (state_reg)
            mnsc_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.wr_en = in_valid && (in_func == mnsc_pkg::FUNC_LOAD);
                cmd.start = in_valid && (in_func == mnsc_pkg::FUNC_QUERY);
            end
            mnsc_pkg::ST_SCAN:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_cmp   = (idx_reg < cnt_reg);
                cmd.rd_first = (idx_reg == '0);
            end
            mnsc_pkg::ST_FINISH:
            begin
                cmd.capture = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
                cmd.rd_idx = idx_reg;
            end
        endcase
    end

    // Next state and counters.
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        seed_count_next = seed_count_reg;
        out_valid_next  = out_valid_reg;

        if (cfg_valid && cfg_ready)
        begin
            seed_count_next = cfg_data;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.capture)
        begin
            out_valid_next = 1'b1;
        end

        case (state_reg)
            mnsc_pkg::ST_IDLE:
            begin
                if (cmd.start)
                begin
                    idx_next   = '0;
                    cnt_next   = (seed_count_reg > DEPTH_C) ? DEPTH_C : seed_count_reg;
                    state_next = mnsc_pkg::ST_SCAN;
                end
            end
            mnsc_pkg::ST_SCAN:
            begin
                idx_next = idx_reg + mnsc_pkg::COUNT_W'(1);
                if (scan_last)
                begin
                    state_next = mnsc_pkg::ST_DRAIN_A;
                end
            end
            mnsc_pkg::ST_DRAIN_A:
            begin
                state_next = mnsc_pkg::ST_DRAIN_B;
            end
            mnsc_pkg::ST_DRAIN_B:
            begin
                state_next = mnsc_pkg::ST_FINISH;
            end
            mnsc_pkg::ST_FINISH:
            begin
                if (cmd.capture)
                begin
                    state_next = mnsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mnsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mnsc_pkg::ST_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            seed_count_reg <= mnsc_pkg::SEED_COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            seed_count_reg <= seed_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

// File: src/mnsc_datapath.sv
// Datapath of the nearest-seed classifier: seed memory, distance pipeline and best tracker.
// Depends on mnsc_pkg.
module mnsc_datapath #(
    parameter int MAX_SEEDS = mnsc_pkg::MAX_SEEDS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mnsc_pkg::ctrl_cmd_t          cmd,
    input  logic [mnsc_pkg::IDX_W-1:0]   seed_slot,
    input  logic [mnsc_pkg::COORD_W-1:0] seed_x,
    input  logic [mnsc_pkg::COORD_W-1:0] seed_y,
    input  logic                         seed_land,
    input  logic [mnsc_pkg::COORD_W-1:0] pixel_x,
    input  logic [mnsc_pkg::COORD_W-1:0] pixel_y,
    output logic [mnsc_pkg::IDX_W-1:0]   nearest_index,
    output logic                         is_land,
    output logic [mnsc_pkg::DIST_W-1:0]  best_distance
);

    localparam int DEPTH = (MAX_SEEDS < mnsc_pkg::SLOT_COUNT) ? MAX_SEEDS
                                                              : mnsc_pkg::SLOT_COUNT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mnsc_pkg::seed_entry_t seed_mem [DEPTH];

    logic [mnsc_pkg::COORD_W-1:0] px_reg, py_reg;
    mnsc_pkg::seed_entry_t        rd_data_reg;
    logic                         s2_valid_reg, s2_cmp_reg, s2_first_reg;
    logic [mnsc_pkg::IDX_W-1:0]   s2_idx_reg;
    logic                         s3_valid_reg, s3_cmp_reg, s3_first_reg, s3_land_reg;
    logic [mnsc_pkg::IDX_W-1:0]   s3_idx_reg;
    logic [mnsc_pkg::DIST_W:0]    dist_reg;
    logic [mnsc_pkg::DIST_W-1:0]  best_dist_reg;
    logic [mnsc_pkg::IDX_W-1:0]   best_idx_reg;
    logic                         best_land_reg;
    logic [mnsc_pkg::IDX_W-1:0]   out_idx_reg;
    logic                         out_land_reg;
    logic [mnsc_pkg::DIST_W-1:0]  out_dist_reg;

    logic [mnsc_pkg::COORD_W-1:0] dx, dy;
    logic [mnsc_pkg::DIST_W:0]    dist_sum;
    logic                         slot_ok;
    logic                         closer;

    assign slot_ok = (32'(seed_slot) < DEPTH);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && slot_ok)
        begin
            seed_mem[seed_slot[AW-1:0]] <= '{x: seed_x, y: seed_y, land: seed_land};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= seed_mem[cmd.rd_idx[AW-1:0]];
        end
    end

    assign dx = (px_reg >= rd_data_reg.x) ? (px_reg - rd_data_reg.x) : (rd_data_reg.x - px_reg);
    assign dy = (py_reg >= rd_data_reg.y) ? (py_reg - rd_data_reg.y) : (rd_data_reg.y - py_reg);
    assign dist_sum = {1'b0, dx} + {1'b0, dy};

    assign closer = s3_cmp_reg && (dist_reg < {1'b0, best_dist_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= cmd.rd_en;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
        s2_cmp_reg   <= cmd.rd_cmp;
        s2_first_reg <= cmd.rd_first;
        s2_idx_reg   <= cmd.rd_idx[mnsc_pkg::IDX_W-1:0];

        s3_cmp_reg   <= s2_valid_reg && s2_cmp_reg;
        s3_first_reg <= s2_valid_reg && s2_first_reg;
        s3_idx_reg   <= s2_idx_reg;
        s3_land_reg  <= rd_data_reg.land;
        dist_reg     <= dist_sum;

        if (cmd.start)
        begin
            best_dist_reg <= mnsc_pkg::DIST_BOUND;
            best_idx_reg  <= '0;
            best_land_reg <= 1'b0;
        end
        else if (s3_valid_reg && closer)
        begin
            best_dist_reg <= dist_reg[mnsc_pkg::DIST_W-1:0];
            best_idx_reg  <= s3_idx_reg;
            best_land_reg <= s3_land_reg;
        end
        else if (s3_valid_reg && s3_first_reg)
        begin
            // Entry 0 is the fallback answer, so its class is kept even when it loses.
            best_land_reg <= s3_land_reg;
        end

        if (cmd.capture)
        begin
            out_idx_reg  <= best_idx_reg;
            out_land_reg <= best_land_reg;
            out_dist_reg <= best_dist_reg;
        end
    end

    assign nearest_index = out_idx_reg;
    assign is_land       = out_land_reg;
    assign best_distance = out_dist_reg;

endmodule

// File: src/manhattan_nearest_seed_classifier.sv
// Top level of the Manhattan nearest-seed classifier.
// Depends on mnsc_pkg, the channel interfaces, mnsc_ctrl and mnsc_datapath.
//
// The block holds a table of seed points (x, y and a land flag) and answers
// pixel queries with the seed at the smallest Manhattan distance.
// Channels: req carries load and query requests, rsp carries one result per
// query, cfg writes the seed_count register. A request moves on an edge
// where valid and ready are both high; cfg is always ready and is only to be
// written while the block is idle.
// A load is taken while idle and gives no result. A query reads one seed
// entry per cycle from the single read port of the seed memory, so it reads
// N = max(1, min(seed_count, MAX_SEEDS, 64)) entries; the controller then passes
// through DRAIN_A, DRAIN_B and FINISH, the result is captured into the output
// register in FINISH, and a new request is accepted once the block is back in idle.
// Results sit in an output register: when the receiver stalls, the next
// request is still taken and scanned, and only its hand-off waits.
// Reset clears the control state and sets seed_count to 64; the seed table is
// not cleared, and entries must be loaded before any query searches them.
module manhattan_nearest_seed_classifier #(
    parameter int MAX_SEEDS = mnsc_pkg::MAX_SEEDS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    mnsc_req_if.sink    req,
    mnsc_rsp_if.source  rsp,
    mnsc_cfg_if.sink    cfg
);

    mnsc_pkg::ctrl_cmd_t cmd;

    // The controller owns the handshakes, the count register and the scan index.
    mnsc_ctrl #(
        .MAX_SEEDS (MAX_SEEDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_func   (req.func),
        .in_ready  (req.ready),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.data),
        .cfg_ready (cfg.ready),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .cmd       (cmd)
    );

    // The datapath holds the seed memory, the distance pipeline and the result register.
    mnsc_datapath #(
        .MAX_SEEDS (MAX_SEEDS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .seed_slot     (req.seed_slot),
        .seed_x        (req.seed_x),
        .seed_y        (req.seed_y),
        .seed_land     (req.seed_land),
        .pixel_x       (req.pixel_x),
        .pixel_y       (req.pixel_y),
        .nearest_index (rsp.nearest_index),
        .is_land       (rsp.is_land),
        .best_distance (rsp.best_distance)
    );

endmodule

// File: src/mnsc_checker.sv
// Port-level checker for the nearest-seed classifier, bound to the top level.
// Depends on mnsc_pkg and on the top level's interface ports.
module mnsc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         req_func,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [mnsc_pkg::IDX_W-1:0]   rsp_nearest_index,
    input logic                         rsp_is_land,
    input logic [mnsc_pkg::DIST_W-1:0]  rsp_best_distance
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nearest_index)
            && $stable(rsp_is_land) && $stable(rsp_best_distance))
    else $error("stalled result changed");

    // The best distance never exceeds the starting bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_best_distance <= mnsc_pkg::DIST_BOUND)
    else $error("best distance above bound");

    // When nothing beats the bound, the answer is seed 0.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_best_distance == mnsc_pkg::DIST_BOUND |-> rsp_nearest_index == '0)
    else $error("bound distance with non-zero index");

    // A query cannot produce its result on the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_func == mnsc_pkg::FUNC_QUERY |=> !$rose(rsp_valid))
    else $error("result appeared too early after a query");

endmodule

bind manhattan_nearest_seed_classifier mnsc_checker u_mnsc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .req_func          (req.func),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_nearest_index (rsp.nearest_index),
    .rsp_is_land       (rsp.is_land),
    .rsp_best_distance (rsp.best_distance)
);

// File: verif/manhattan_nearest_seed_classifier_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for manhattan_nearest_seed_classifier: seed loads, pixel queries and
// seed_count sweeps, with every query answer checked against a built-in nearest-seed search.
// Depends on mnsc_pkg, the channel interfaces in mnsc_if.sv and the block's RTL.

class seed_search_board;
    typedef struct packed {
        logic [mnsc_pkg::IDX_W-1:0]  index;
        logic                        land;
        logic [mnsc_pkg::DIST_W-1:0] distance;
    } answer_t;

    logic [mnsc_pkg::COORD_W-1:0] x_tab [mnsc_pkg::SLOT_COUNT];
    logic [mnsc_pkg::COORD_W-1:0] y_tab [mnsc_pkg::SLOT_COUNT];
    logic                         land_tab [mnsc_pkg::SLOT_COUNT];
    bit                           loaded [mnsc_pkg::SLOT_COUNT];
    logic [mnsc_pkg::COUNT_W-1:0] seed_count;
    answer_t                      awaited [$];
    int faults;
    int loads;
    int queries;
    int settings;
    int bound_answers;
    int exact_hits;
    int ties;

    function new();
        seed_count = mnsc_pkg::SEED_COUNT_RESET;
    endfunction

    function void set_count(logic [mnsc_pkg::COUNT_W-1:0] value);
        seed_count = value;
        settings++;
    endfunction

    // Number of table entries one query walks through; counts above the table saturate.
    function int searched();
        if (seed_count > mnsc_pkg::MAX_SEEDS_DEFAULT)
            return mnsc_pkg::MAX_SEEDS_DEFAULT;
        return seed_count;
    endfunction

    // A query may only be sent once every entry it reads has been loaded. With a count of
    // zero the answer still carries the class flag of entry 0, so that entry must be loaded.
    function bit query_safe();
        int last;
        int i;
        last = (searched() == 0) ? 1 : searched();
        for (i = 0; i < last; i++)
            if (!loaded[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function int outstanding();
        return awaited.size();
    endfunction

    function void note_request(logic func, logic [mnsc_pkg::IDX_W-1:0] slot,
                               logic [mnsc_pkg::COORD_W-1:0] sx, logic [mnsc_pkg::COORD_W-1:0] sy,
                               logic sland, logic [mnsc_pkg::COORD_W-1:0] px,
                               logic [mnsc_pkg::COORD_W-1:0] py);
        answer_t answer;
        int      best;
        int      best_i;
        int      dx;
        int      dy;
        int      i;
        bit      tied;
        if (func == mnsc_pkg::FUNC_LOAD) begin
            x_tab[slot]    = sx;
            y_tab[slot]    = sy;
            land_tab[slot] = sland;
            loaded[slot]   = 1'b1;
            loads++;
            return;
        end
        queries++;
        best   = mnsc_pkg::DIST_BOUND;
        best_i = 0;
        tied   = 1'b0;
        for (i = 0; i < searched(); i++) begin
            dx = (px > x_tab[i]) ? px - x_tab[i] : x_tab[i] - px;
            dy = (py > y_tab[i]) ? py - y_tab[i] : y_tab[i] - py;
            if (dx + dy < best) begin
                best   = dx + dy;
                best_i = i;
                tied   = 1'b0;
            end
            else if (dx + dy == best && best < mnsc_pkg::DIST_BOUND)
                tied = 1'b1;
        end
        answer.index    = mnsc_pkg::IDX_W'(best_i);
        answer.land     = land_tab[best_i];
        answer.distance = mnsc_pkg::DIST_W'(best);
        if (best == mnsc_pkg::DIST_BOUND)
            bound_answers++;
        if (best == 0)
            exact_hits++;
        if (tied)
            ties++;
        awaited.push_back(answer);
    endfunction

    function void check_result(logic [mnsc_pkg::IDX_W-1:0] index, logic land,
                               logic [mnsc_pkg::DIST_W-1:0] distance);
        answer_t want;
        if (awaited.size() == 0) begin
            faults++;
            if (faults <= 10)
                $display("Unexpected result at %0t: index %0d land %0b distance %0d",
                         $time, index, land, distance);
            return;
        end
        want = awaited.pop_front();
        if (want.index !== index || want.land !== land || want.distance !== distance) begin
            faults++;
            if (faults <= 10)
                $display({"Mismatch at %0t: expected index %0d land %0b distance %0d, ",
                          "got index %0d land %0b distance %0d"},
                         $time, want.index, want.land, want.distance, index, land, distance);
        end
    endfunction
endclass

module manhattan_nearest_seed_classifier_tb;

    // A query reads at most MAX_SEEDS entries, so this margin is ample for the block to
    // fall idle after the last request before seed_count is rewritten or the run ends.
    localparam int SETTLE_CYCLES = mnsc_pkg::MAX_SEEDS_DEFAULT + 16;
    localparam int RANDOM_PHASES = 8;

    logic clk;
    logic rst_n;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;

    seed_search_board board;

    mnsc_req_if req_ch ();
    mnsc_rsp_if rsp_ch ();
    mnsc_cfg_if cfg_ch ();

    manhattan_nearest_seed_classifier uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The receiver decides at each falling edge whether it will take a result at the next
    // rising edge; the stall rate follows the current idling mode.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // All handshakes are observed at the rising edge, in one process, so the register
    // write, the request and the result of one edge are seen in a fixed order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                board.set_count(cfg_ch.data);
            if (req_ch.valid && req_ch.ready)
                board.note_request(req_ch.func, req_ch.seed_slot, req_ch.seed_x, req_ch.seed_y,
                                   req_ch.seed_land, req_ch.pixel_x, req_ch.pixel_y);
            if (rsp_ch.valid && rsp_ch.ready)
                board.check_result(rsp_ch.nearest_index, rsp_ch.is_land, rsp_ch.best_distance);
        end
    end

    // Presents one request from a falling edge and holds it until accepted. Idle cycles in
    // front of it are drawn from the sender's idle rate. Returns at a falling edge with
    // valid still high, so the next request can follow without a gap.
    task automatic send_request(input logic func, input logic [mnsc_pkg::IDX_W-1:0] slot,
                                input logic [mnsc_pkg::COORD_W-1:0] sx,
                                input logic [mnsc_pkg::COORD_W-1:0] sy,
                                input logic sland, input logic [mnsc_pkg::COORD_W-1:0] px,
                                input logic [mnsc_pkg::COORD_W-1:0] py);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.func      = func;
        req_ch.seed_slot = slot;
        req_ch.seed_x    = sx;
        req_ch.seed_y    = sy;
        req_ch.seed_land = sland;
        req_ch.pixel_x   = px;
        req_ch.pixel_y   = py;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Loads carry random pixel fields and queries random seed fields: the block must ignore them.
    task automatic send_load(input int slot, input int sx, input int sy, input int sland);
        send_request(mnsc_pkg::FUNC_LOAD, mnsc_pkg::IDX_W'(slot), mnsc_pkg::COORD_W'(sx),
                     mnsc_pkg::COORD_W'(sy), 1'(sland),
                     mnsc_pkg::COORD_W'($urandom_range(1023)),
                     mnsc_pkg::COORD_W'($urandom_range(1023)));
    endtask

    task automatic send_query(input int px, input int py);
        send_request(mnsc_pkg::FUNC_QUERY, mnsc_pkg::IDX_W'($urandom_range(63)),
                     mnsc_pkg::COORD_W'($urandom_range(1023)),
                     mnsc_pkg::COORD_W'($urandom_range(1023)), 1'($urandom_range(1)),
                     mnsc_pkg::COORD_W'(px), mnsc_pkg::COORD_W'(py));
    endtask

    // Waits until every expected result has been handed over and the block has had time
    // to finish anything still in flight.
    task automatic wait_idle();
        req_ch.valid = 1'b0;
        while (board.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_seed_count(input int value);
        wait_idle();
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = mnsc_pkg::COUNT_W'(value);
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // One random request. Until the searched part of the table is fully loaded, the lowest
    // empty entry is filled first, so that no query ever reads an entry that was never
    // written. After that most requests are queries aimed at or near loaded seeds, so that
    // small distances and ties are common, with plain random pixels and corners besides.
    task automatic send_random_item();
        int span;
        int slot;
        int other;
        int second;
        int px;
        int py;
        span = (board.searched() == 0) ? 1 : board.searched();
        if (!board.query_safe())
        begin
            slot = 0;
            while (board.loaded[slot])
                slot++;
            send_load(slot, $urandom_range(1023), $urandom_range(1023), $urandom_range(1));
            return;
        end
        other  = $urandom_range(span - 1);
        second = $urandom_range(span - 1);
        if ($urandom_range(99) < 30)
        begin
            slot = $urandom_range(mnsc_pkg::SLOT_COUNT - 1);
            case ($urandom_range(3))
                0:       send_load(slot, board.x_tab[other], board.y_tab[other], $urandom_range(1));
                1:       send_load(slot, $urandom_range(1) * 1023, $urandom_range(1) * 1023,
                                   $urandom_range(1));
                default: send_load(slot, $urandom_range(1023), $urandom_range(1023),
                                   $urandom_range(1));
            endcase
            return;
        end
        case ($urandom_range(5))
            0, 1:
            begin
                // Near a seed; the coordinate wraps at the edge of the 10-bit field.
                px = (board.x_tab[other] + $urandom_range(16) - 8) & 10'h3ff;
                py = (board.y_tab[other] + $urandom_range(16) - 8) & 10'h3ff;
            end
            2:
            begin
                px = board.x_tab[other];
                py = board.y_tab[other];
            end
            3:
            begin
                px = $urandom_range(1) * 1023;
                py = $urandom_range(1) * 1023;
            end
            4:
            begin
                // Half way between two seeds, where equal distances are likely.
                px = (board.x_tab[other] + board.x_tab[second]) / 2;
                py = (board.y_tab[other] + board.y_tab[second]) / 2;
            end
            default:
            begin
                px = $urandom_range(1023);
                py = $urandom_range(1023);
            end
        endcase
        send_query(px, py);
    endtask

    initial
    begin
        int phase;
        int n;
        int counts [RANDOM_PHASES];
        board            = new();
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.func      = mnsc_pkg::FUNC_LOAD;
        req_ch.seed_slot = '0;
        req_ch.seed_x    = '0;
        req_ch.seed_y    = '0;
        req_ch.seed_land = 1'b0;
        req_ch.pixel_x   = '0;
        req_ch.pixel_y   = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // The first idling mode: the sender pauses often, the receiver even more.
        send_idle_pct = 35;
        recv_idle_pct = 52;

        // Directed part. A single seed first: an exact hit, a distance far past the bound,
        // one exactly at the bound (which does not count as closer) and one just inside it.
        write_seed_count(1);
        send_load(0, 0, 0, 1);
        send_query(0, 0);
        send_query(1023, 1023);
        send_query(500, 499);
        send_query(499, 499);
        send_load(0, 1023, 1023, 0);
        send_query(1023, 1023);
        send_query(0, 0);

        // With a count of zero nothing is searched: seed 0 at the bound, with its own flag.
        write_seed_count(0);
        send_query(1023, 0);
        send_load(0, 512, 512, 1);
        send_query(512, 512);

        // Three seeds, two of them at the same place: ties must go to the lower index.
        write_seed_count(3);
        send_load(1, 100, 100, 1);
        send_load(2, 100, 100, 0);
        send_query(100, 100);
        send_query(103, 98);
        send_load(1, 0, 1023, 0);
        send_query(102, 100);
        send_query(512, 512);

        // Random part. The first phase runs at the full table and so also fills it. Later
        // phases cover counts above the table, zero, one and random sizes in between.
        counts = '{64, 127, 40, 0, 65, 1, 7, 64};
        counts[2] = $urandom_range(2, 63);
        counts[6] = $urandom_range(2, 63);
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 3)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 35;
            end
            else if (phase == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_seed_count(counts[phase]);
            for (n = 0; n < ((phase == 0) ? 110 : 55); n++)
                send_random_item();
        end

        wait_idle();
        $display("Covered %0d loads and %0d queries over %0d seed_count settings.",
                 board.loads, board.queries, board.settings);
        $display("Answers: %0d at the distance bound, %0d exact hits, %0d ties to the lower index.",
                 board.bound_answers, board.exact_hits, board.ties);
        if (board.faults == 0 && board.outstanding() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this time.
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
src/mnsc_pkg.sv
src/mnsc_if.sv
src/mnsc_ctrl.sv
src/mnsc_datapath.sv
src/manhattan_nearest_seed_classifier.sv
src/mnsc_checker.sv
verif/manhattan_nearest_seed_classifier_tb.sv
